[rtl/core/dst_pkg.sv]
package dst_pkg;

  localparam int SLOTS_DEF       = 64;
  localparam int HANDLE_BITS_DEF = 16;

  localparam int KIND_W   = 3;
  localparam int HANDLE_W = 16;
  localparam int SLOT_W   = 7;
  localparam int RSLOT_W  = 6;

  localparam logic [KIND_W-1:0] REQ_ALLOC   = 3'd0;
  localparam logic [KIND_W-1:0] REQ_INSTALL = 3'd1;
  localparam logic [KIND_W-1:0] REQ_DUP     = 3'd2;
  localparam logic [KIND_W-1:0] REQ_DUP2    = 3'd3;
  localparam logic [KIND_W-1:0] REQ_CLOSE   = 3'd4;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0]   req_type;
    logic [HANDLE_W-1:0] handle;
    logic                handle_present;
    logic [SLOT_W-1:0]   first_slot;
    logic [SLOT_W-1:0]   second_slot;
  } dst_req_t;

  typedef struct packed {
    logic                status;
    logic [RSLOT_W-1:0]  result_slot;
    logic                released_valid;
    logic [HANDLE_W-1:0] released_handle;
    logic                ref_added_valid;
    logic [HANDLE_W-1:0] ref_added_handle;
  } dst_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic commit;
  } dst_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } dst_sts_t;

endpackage

[rtl/core/dst_chan_if.sv]
interface dst_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/dst_free_enc.sv]
module dst_free_enc #(
  parameter int SLOTS = dst_pkg::SLOTS_DEF
) (
  input  logic                       clk,
  input  logic [SLOTS-1:0]           occupied,
  output logic                       free_found,
  output logic [$clog2(SLOTS)-1:0]   free_idx
);
  import dst_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int NG = (SLOTS + 7) / 8;
  localparam int GW = (NG > 1) ? $clog2(NG) : 1;

  logic [NG*8-1:0] occ_pad;
  logic [NG-1:0]   grp_free_nxt;
  logic [2:0]      grp_idx_nxt [NG];
  logic [NG-1:0]   grp_free_r;
  logic [2:0]      grp_idx_r [NG];
  logic [GW+2:0]   pick;

  // slots past the end read as taken
  always_comb begin
    occ_pad = '1;
    occ_pad[SLOTS-1:0] = occupied;
  end

  // first level: lowest free slot inside each group of eight
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_free_nxt[g] = ~&occ_pad[g*8 +: 8];
      grp_idx_nxt[g]  = 3'd0;
      for (int i = 7; i >= 0; i--) begin
        if (!occ_pad[g*8 + i]) grp_idx_nxt[g] = 3'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_free_r <= grp_free_nxt;
    for (int g = 0; g < NG; g++) grp_idx_r[g] <= grp_idx_nxt[g];
  end

  // second level: lowest group with a free slot
  always_comb begin
    pick = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_free_r[g]) pick = {GW'(g), grp_idx_r[g]};
    end
  end

  assign free_found = |grp_free_r;
  assign free_idx   = pick[IW-1:0];

endmodule

[rtl/core/dst_ctrl.sv]
module dst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dst_pkg::dst_sts_t sts,
  output dst_pkg::dst_cmd_t cmd
);
  import dst_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold until the result register can take the item
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/core/dst_datapath.sv]
module dst_datapath #(
  parameter int SLOTS       = dst_pkg::SLOTS_DEF,
  parameter int HANDLE_BITS = dst_pkg::HANDLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dst_pkg::dst_cmd_t cmd,
  output dst_pkg::dst_sts_t sts,
  input  dst_pkg::dst_req_t req,
  output logic              out_valid,
  input  logic              out_ready,
  output dst_pkg::dst_rsp_t rsp
);
  import dst_pkg::*;

  localparam int IW = $clog2(SLOTS);

  logic [HANDLE_BITS-1:0] mem [SLOTS];

  dst_req_t               req_r;
  logic [HANDLE_BITS-1:0] rd_a_r;
  logic [HANDLE_BITS-1:0] rd_b_r;
  logic [SLOTS-1:0]       occupied_r;
  logic [SLOTS-1:0]       occupied_nxt;
  logic                   out_valid_r;
  dst_rsp_t               rsp_r;
  dst_rsp_t               rsp_nxt;

  logic                   free_found;
  logic [IW-1:0]          free_idx;

  logic                   a_ok;
  logic                   b_ok;
  logic [IW-1:0]          a_idx;
  logic [IW-1:0]          b_idx;
  logic                   occ_a;
  logic                   occ_b;
  logic [HANDLE_BITS-1:0] h_in;

  logic                   wr_en;
  logic [IW-1:0]          wr_idx;
  logic [HANDLE_BITS-1:0] wr_data;

  dst_free_enc #(
    .SLOTS(SLOTS)
  ) u_free (
    .clk        (clk),
    .occupied   (occupied_r),
    .free_found (free_found),
    .free_idx   (free_idx)
  );

  // handle store: both slot reads registered at request load
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= req;
      rd_a_r <= mem[req.first_slot[IW-1:0]];
      rd_b_r <= mem[req.second_slot[IW-1:0]];
    end
    if (cmd.commit && wr_en) mem[wr_idx] <= wr_data;
  end

  assign a_ok  = req_r.first_slot < SLOT_W'(SLOTS);
  assign b_ok  = req_r.second_slot < SLOT_W'(SLOTS);
  assign a_idx = req_r.first_slot[IW-1:0];
  assign b_idx = req_r.second_slot[IW-1:0];
  assign occ_a = a_ok && occupied_r[a_idx];
  assign occ_b = b_ok && occupied_r[b_idx];
  assign h_in  = HANDLE_BITS'(req_r.handle);

  always_comb begin
    occupied_nxt = occupied_r;
    wr_en        = 1'b0;
    wr_idx       = free_idx;
    wr_data      = rd_a_r;
    rsp_nxt      = '0;
    rsp_nxt.status = ST_ERR;
    case (req_r.req_type)
      REQ_ALLOC: begin
        if (req_r.handle_present && free_found) begin
          wr_en                  = 1'b1;
          wr_data                = h_in;
          occupied_nxt[free_idx] = 1'b1;
          rsp_nxt.status         = ST_OK;
          rsp_nxt.result_slot    = RSLOT_W'(free_idx);
        end
      end
      REQ_INSTALL: begin
        if (a_ok) begin
          wr_en                   = req_r.handle_present;
          wr_idx                  = a_idx;
          wr_data                 = h_in;
          occupied_nxt[a_idx]     = req_r.handle_present;
          rsp_nxt.status          = ST_OK;
          rsp_nxt.result_slot     = RSLOT_W'(a_idx);
          rsp_nxt.released_valid  = occ_a;
          rsp_nxt.released_handle = occ_a ? HANDLE_W'(rd_a_r) : '0;
        end
      end
      REQ_DUP: begin
        if (occ_a && free_found) begin
          wr_en                    = 1'b1;
          occupied_nxt[free_idx]   = 1'b1;
          rsp_nxt.status           = ST_OK;
          rsp_nxt.result_slot      = RSLOT_W'(free_idx);
          rsp_nxt.ref_added_valid  = 1'b1;
          rsp_nxt.ref_added_handle = HANDLE_W'(rd_a_r);
        end
      end
      REQ_DUP2: begin
        if (occ_a && b_ok) begin
          rsp_nxt.status      = ST_OK;
          rsp_nxt.result_slot = RSLOT_W'(b_idx);
          // copy onto itself leaves the table alone
          if (req_r.first_slot != req_r.second_slot) begin
            wr_en                    = 1'b1;
            wr_idx                   = b_idx;
            occupied_nxt[b_idx]      = 1'b1;
            rsp_nxt.released_valid   = occ_b;
            rsp_nxt.released_handle  = occ_b ? HANDLE_W'(rd_b_r) : '0;
            rsp_nxt.ref_added_valid  = 1'b1;
            rsp_nxt.ref_added_handle = HANDLE_W'(rd_a_r);
          end
        end
      end
      REQ_CLOSE: begin
        if (a_ok) begin
          occupied_nxt[a_idx]     = 1'b0;
          rsp_nxt.status          = ST_OK;
          rsp_nxt.released_valid  = occ_a;
          rsp_nxt.released_handle = occ_a ? HANDLE_W'(rd_a_r) : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occupied_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        occupied_r  <= occupied_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) rsp_r <= rsp_nxt;
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign rsp          = rsp_r;

  a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("commit while result register is held");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed item not presented");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rsp_r.status == ST_ERR) |->
      (rsp_r.result_slot == '0 && !rsp_r.released_valid && !rsp_r.ref_added_valid))
    else $error("error result carries data");

  a_err_keeps_table: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && rsp_nxt.status == ST_ERR) |=> $stable(occupied_r))
    else $error("error request changed the slot table");

  a_dup_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && rsp_nxt.ref_added_valid) |=> occupied_r[$past(wr_idx)])
    else $error("copied slot not marked occupied");

endmodule

[rtl/core/descriptor_slot_table.sv]
// Descriptor slot table with lowest-free allocation. Each request is handled
// in a load step that reads the handle store at the source and destination
// slots, then a commit step that updates the table and registers the result;
// the commit waits only while the previous result has not been taken. The next
// request is accepted while a finished result waits at the output. Occupancy is
// kept in flip-flops cleared by reset, so no clearing pass is needed; the lowest
// free slot comes from a two-level encoder over the occupancy bits, refreshed
// every cycle. Handles are stored at HANDLE_BITS bits and reported at 16 bits.
module descriptor_slot_table #(
  parameter int SLOTS       = dst_pkg::SLOTS_DEF,
  parameter int HANDLE_BITS = dst_pkg::HANDLE_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  dst_chan_if.sink   in_req,
  dst_chan_if.source out_rsp
);
  import dst_pkg::*;

  dst_cmd_t cmd;
  dst_sts_t sts;
  dst_rsp_t rsp;
  logic     out_valid;

  dst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dst_datapath #(
    .SLOTS       (SLOTS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .req       (in_req.data),
    .out_valid (out_valid),
    .out_ready (out_rsp.ready),
    .rsp       (rsp)
  );

  assign out_rsp.valid = out_valid;
  assign out_rsp.data  = rsp;

endmodule
